// ===== hw/rtl/vpw_pkg.sv =====
// Shared constants, types and saturation helper for the vertex projection block.
package vpw_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int FIELD_W       = 32;
    localparam int EFF_W         = (VALUE_WIDTH > FIELD_W) ? FIELD_W : VALUE_WIDTH;
    localparam int MUL_W         = FIELD_W + 1;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int ACC_W         = PROD_W + 2;
    localparam int STORE_DEPTH   = 32;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int VIEW_W        = 16;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_PROJECT = 1'b1;

    localparam logic signed [MUL_W-1:0] ONE_M =
        {{(MUL_W-1){1'b0}}, 1'b1} << FRACTION_BITS;
    localparam logic signed [ACC_W-1:0] ONE_A =
        {{(ACC_W-1){1'b0}}, 1'b1} << FRACTION_BITS;
    localparam logic signed [ACC_W-1:0] HALF_A =
        {{(ACC_W-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_WIDTH    = 2'd2,
        CFG_HEIGHT   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Clamp a wide signed value to the signed range of EFF_W bits.
    function automatic logic signed [FIELD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-1){1'b0}}, 1'b1} << (EFF_W - 1);
        hi = hi - ACC_W'(1);
        lo = ~hi;
        if (v > hi) begin
            return hi[FIELD_W-1:0];
        end else if (v < lo) begin
            return lo[FIELD_W-1:0];
        end
        return v[FIELD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/vertex_project_to_window.sv =====
// Top level: matrix store, shared multiply-accumulate, divide and viewport mapping.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_mode, i_coeff_index, i_coeff_value,
//          |           |                         | i_obj_x, i_obj_y, i_obj_z
//  out     | output    | o_out_valid/i_out_stall | o_ok, o_win_x, o_win_y, o_win_z
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A load item writes its coefficient into the store as it is accepted.
// A project item works in Q16.16: two passes through the single 33x33 multiplier and
// accumulator, then, if w is nonzero, three divides in the bit-serial divider (one
// quotient bit per cycle) and viewport mapping.
// Reset is synchronous and active low; it clears the per-entry valid bits of the store, so
// every coefficient reads as zero until loaded, and the viewport registers.
// A finished result waits in the output register while the next item is already accepted;
// the block only holds a project item in its last step while that register is still full.
module vertex_project_to_window (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic                                    i_mode,
    input  logic [vpw_pkg::ADDR_W-1:0]              i_coeff_index,
    input  logic signed [vpw_pkg::FIELD_W-1:0]      i_coeff_value,
    input  logic signed [vpw_pkg::FIELD_W-1:0]      i_obj_x,
    input  logic signed [vpw_pkg::FIELD_W-1:0]      i_obj_y,
    input  logic signed [vpw_pkg::FIELD_W-1:0]      i_obj_z,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic                                    o_ok,
    output logic signed [vpw_pkg::FIELD_W-1:0]      o_win_x,
    output logic signed [vpw_pkg::FIELD_W-1:0]      o_win_y,
    output logic signed [vpw_pkg::FIELD_W-1:0]      o_win_z,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [vpw_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [vpw_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_DIV_GO, S_DIV_WAIT, S_WIN_MUL, S_WIN_ADD, S_DONE
    } t_state;

    // Store and its per-entry valid bits.
    logic [vpw_pkg::FIELD_W-1:0]          r_store [vpw_pkg::STORE_DEPTH];
    logic [vpw_pkg::STORE_DEPTH-1:0]      r_store_vld;
    logic [vpw_pkg::FIELD_W-1:0]          r_rd_data;
    logic                                 r_rd_vld;

    t_state                               r_state;
    logic                                 r_phase;
    logic [4:0]                           r_cnt;
    logic [1:0]                           r_k;
    logic                                 r_fail;

    logic                                 r_s1_v;
    logic [1:0]                           r_s1_j;
    logic [1:0]                           r_s1_r;
    logic                                 r_s2_v;
    logic [1:0]                           r_s2_j;
    logic [1:0]                           r_s2_r;

    logic signed [vpw_pkg::FIELD_W-1:0]   r_obj  [3];
    logic signed [vpw_pkg::FIELD_W-1:0]   r_eye  [4];
    logic signed [vpw_pkg::FIELD_W-1:0]   r_clip [4];
    logic signed [vpw_pkg::FIELD_W-1:0]   r_ndc  [3];
    logic signed [vpw_pkg::FIELD_W-1:0]   r_win  [2];
    logic signed [vpw_pkg::ACC_W-1:0]     r_acc;
    logic signed [vpw_pkg::PROD_W-1:0]    r_prod;

    logic signed [vpw_pkg::VIEW_W-1:0]    r_origin_x;
    logic signed [vpw_pkg::VIEW_W-1:0]    r_origin_y;
    logic [vpw_pkg::VIEW_W-1:0]           r_width;
    logic [vpw_pkg::VIEW_W-1:0]           r_height;

    logic                                 r_out_valid;

    logic                                 in_acc;
    logic                                 out_free;
    logic                                 issue;
    logic [vpw_pkg::ADDR_W-1:0]           rd_addr;
    logic signed [vpw_pkg::MUL_W-1:0]     mul_a;
    logic signed [vpw_pkg::MUL_W-1:0]     mul_b;
    logic signed [vpw_pkg::PROD_W-1:0]    prod_c;
    logic signed [vpw_pkg::ACC_W-1:0]     acc_sum;
    logic signed [vpw_pkg::FIELD_W-1:0]   row_res;
    logic signed [vpw_pkg::VIEW_W-1:0]    sel_origin;
    logic [vpw_pkg::VIEW_W-1:0]           sel_size;
    logic signed [vpw_pkg::FIELD_W-1:0]   win_c;
    logic signed [vpw_pkg::FIELD_W-1:0]   win_z_c;
    logic                                 div_start;
    vpw_pkg::t_div_stat                   div_stat;
    logic signed [vpw_pkg::FIELD_W-1:0]   div_quot;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;

    // Count bits [3:2] pick the row and [1:0] the column, so a row's four terms run together.
    assign issue   = (r_state == S_MAC) && !r_cnt[4];
    assign rd_addr = {r_phase, r_cnt[1:0], r_cnt[3:2]};

    // Shared multiplier: matrix terms during the two passes, viewport scale afterwards.
    always_comb begin
        if (r_state == S_WIN_MUL) begin
            mul_a = vpw_pkg::MUL_W'(r_ndc[r_k]) + vpw_pkg::ONE_M;
            mul_b = vpw_pkg::MUL_W'({1'b0, sel_size});
        end else begin
            if (r_phase) begin
                mul_a = vpw_pkg::MUL_W'(r_eye[r_s1_j]);
            end else if (r_s1_j == 2'd3) begin
                mul_a = vpw_pkg::ONE_M;
            end else begin
                mul_a = vpw_pkg::MUL_W'(r_obj[r_s1_j]);
            end
            mul_b = r_rd_vld ? vpw_pkg::MUL_W'($signed(r_rd_data)) : '0;
        end
    end

    assign prod_c = mul_a * mul_b;

    // The rounding half is preloaded with the first term, so the last term finishes the row.
    assign acc_sum = ((r_s2_j == 2'd0) ? vpw_pkg::HALF_A : r_acc)
                   + vpw_pkg::ACC_W'(r_prod);
    assign row_res = vpw_pkg::sat_acc(acc_sum >>> vpw_pkg::FRACTION_BITS);

    assign sel_origin = (r_k == 2'd0) ? r_origin_x : r_origin_y;
    assign sel_size   = (r_k == 2'd0) ? r_width : r_height;
    assign win_c = vpw_pkg::sat_acc((vpw_pkg::ACC_W'(sel_origin) <<< vpw_pkg::FRACTION_BITS)
                 + ((vpw_pkg::ACC_W'(r_prod) + vpw_pkg::ACC_W'(1)) >>> 1));
    assign win_z_c = vpw_pkg::sat_acc((vpw_pkg::ONE_A + vpw_pkg::ACC_W'(r_ndc[2])
                   + vpw_pkg::ACC_W'(1)) >>> 1);

    assign div_start = (r_state == S_DIV_GO) && (r_clip[3] != '0);

    vpw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_clip  (r_clip[r_k]),
        .i_w     (r_clip[3]),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // Coefficient store: written by load items, read one entry per cycle during the passes.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_mode == vpw_pkg::MODE_LOAD)) begin
            r_store[i_coeff_index] <= i_coeff_value;
        end
        r_rd_data <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_vld <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (in_acc && (i_mode == vpw_pkg::MODE_LOAD)) begin
                r_store_vld[i_coeff_index] <= 1'b1;
            end
            r_rd_vld <= r_store_vld[rd_addr];
        end
    end

    // Viewport registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_width    <= '0;
            r_height   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (vpw_pkg::t_cfg_idx'(i_cfg_index))
                vpw_pkg::CFG_ORIGIN_X: r_origin_x <= $signed(i_cfg_data);
                vpw_pkg::CFG_ORIGIN_Y: r_origin_y <= $signed(i_cfg_data);
                vpw_pkg::CFG_WIDTH:    r_width    <= i_cfg_data;
                vpw_pkg::CFG_HEIGHT:   r_height   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        r_s1_j <= r_cnt[1:0];
        r_s1_r <= r_cnt[3:2];
        r_s2_j <= r_s1_j;
        r_s2_r <= r_s1_r;
        if (r_s2_v) begin
            r_acc <= acc_sum;
            if (r_s2_j == 2'd3) begin
                if (r_phase) begin
                    r_clip[r_s2_r] <= row_res;
                end else begin
                    r_eye[r_s2_r] <= row_res;
                end
            end
        end
        if (in_acc) begin
            r_obj[0] <= i_obj_x;
            r_obj[1] <= i_obj_y;
            r_obj[2] <= i_obj_z;
        end
        if ((r_state == S_DIV_WAIT) && div_stat.done) begin
            r_ndc[r_k] <= div_quot;
        end
        if (r_state == S_WIN_ADD) begin
            r_win[r_k[0]] <= win_c;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_fail      <= 1'b0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_mode == vpw_pkg::MODE_PROJECT)) begin
                        r_phase <= 1'b0;
                        r_cnt   <= '0;
                        r_fail  <= 1'b0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    // The last read still passes the read-data and product registers before its row lands.
                    if (r_cnt == 5'd17) begin
                        r_cnt <= '0;
                        if (r_phase) begin
                            r_k     <= 2'd0;
                            r_state <= S_DIV_GO;
                        end else begin
                            r_phase <= 1'b1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_DIV_GO: begin
                    if (r_clip[3] == '0) begin
                        r_fail  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_stat.done) begin
                        if (r_k == 2'd2) begin
                            r_k     <= 2'd0;
                            r_state <= S_WIN_MUL;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_WIN_MUL: begin
                    r_state <= S_WIN_ADD;
                end
                S_WIN_ADD: begin
                    if (r_k == 2'd1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= 2'd1;
                        r_state <= S_WIN_MUL;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        o_ok        <= !r_fail;
                        o_win_x     <= r_fail ? '0 : r_win[0];
                        o_win_y     <= r_fail ? '0 : r_win[1];
                        o_win_z     <= r_fail ? '0 : win_z_c;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_cnt <= 5'd17))
        else $error("pass counter ran past the pipeline drain");

    a_tag_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> $past(r_s1_v))
        else $error("product stage valid without a read before it");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_win_x == '0 && o_win_y == '0 && o_win_z == '0))
        else $error("failed projection carries nonzero coordinates");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished item not moved into the output register");

endmodule

// ===== hw/rtl/vpw_div.sv =====
// Bit-serial rounding divider: clip * one / w, saturated.
module vpw_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [vpw_pkg::FIELD_W-1:0] i_clip,
    input  logic signed [vpw_pkg::FIELD_W-1:0] i_w,
    output vpw_pkg::t_div_stat                o_stat,
    output logic signed [vpw_pkg::FIELD_W-1:0] o_quot
);

    localparam int NUM_W = vpw_pkg::FIELD_W + vpw_pkg::FRACTION_BITS;
    localparam int DVD_W = NUM_W + 1;
    localparam int REM_W = vpw_pkg::FIELD_W + 1;
    localparam int CNT_W = $clog2(DVD_W + 1);

    typedef enum logic [1:0] {D_IDLE, D_PREP, D_RUN, D_FIN} t_dstate;

    t_dstate                       r_state;
    logic                          r_neg;
    logic [NUM_W-1:0]              r_n;
    logic [vpw_pkg::FIELD_W-1:0]   r_d;
    logic [DVD_W-1:0]              r_dvd;
    logic [REM_W-1:0]              r_rem;
    logic [CNT_W-1:0]              r_cnt;

    logic signed [NUM_W-1:0]       num;
    logic [REM_W-1:0]              rem_sh;
    logic                          ge;
    logic [DVD_W-1:0]              smax;

    assign num    = {i_clip, {vpw_pkg::FRACTION_BITS{1'b0}}};
    assign rem_sh = {r_rem[REM_W-2:0], r_dvd[DVD_W-1]};
    assign ge     = (rem_sh >= REM_W'(r_d));
    assign smax   = ({{(DVD_W-1){1'b0}}, 1'b1} << (vpw_pkg::EFF_W - 1)) - DVD_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_clip[vpw_pkg::FIELD_W-1] ^ i_w[vpw_pkg::FIELD_W-1];
                        r_n     <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                        r_d     <= i_w[vpw_pkg::FIELD_W-1] ? vpw_pkg::FIELD_W'(-i_w)
                                                           : vpw_pkg::FIELD_W'(i_w);
                        r_state <= D_PREP;
                    end
                end
                D_PREP: begin
                    // Adding half the divisor makes the truncating loop round to nearest.
                    r_dvd   <= DVD_W'(r_n) + DVD_W'(r_d >> 1);
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(DVD_W);
                    r_state <= D_RUN;
                end
                D_RUN: begin
                    r_rem <= ge ? (rem_sh - REM_W'(r_d)) : rem_sh;
                    r_dvd <= {r_dvd[DVD_W-2:0], ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        if (!r_neg) begin
            o_quot = (r_dvd > smax) ? vpw_pkg::FIELD_W'(smax) : r_dvd[vpw_pkg::FIELD_W-1:0];
        end else if (r_dvd > smax + DVD_W'(1)) begin
            o_quot = ~vpw_pkg::FIELD_W'(smax);
        end else begin
            o_quot = vpw_pkg::FIELD_W'(DVD_W'(0) - r_dvd);
        end
    end

    assign o_stat.busy = (r_state != D_IDLE);
    assign o_stat.done = (r_state == D_FIN);

endmodule

// ===== tb/sv/tb_vertex_project_to_window.sv =====
// Testbench for vertex_project_to_window: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module tb_vertex_project_to_window;

    // One input item as it crosses the input handshake.
    typedef struct {
        logic                               mode;
        logic [vpw_pkg::ADDR_W-1:0]         coeff_index;
        logic signed [vpw_pkg::FIELD_W-1:0] coeff_value;
        logic signed [vpw_pkg::FIELD_W-1:0] obj_x;
        logic signed [vpw_pkg::FIELD_W-1:0] obj_y;
        logic signed [vpw_pkg::FIELD_W-1:0] obj_z;
    } t_vertex_item;

    // One window-space result item.
    typedef struct {
        logic                               ok;
        logic signed [vpw_pkg::FIELD_W-1:0] win_x;
        logic signed [vpw_pkg::FIELD_W-1:0] win_y;
        logic signed [vpw_pkg::FIELD_W-1:0] win_z;
    } t_window_point;

    localparam longint FX_ONE  = 64'sd1 << vpw_pkg::FRACTION_BITS;
    localparam longint FX_MAX  = (64'sd1 <<< (vpw_pkg::EFF_W - 1)) - 1;
    localparam longint FX_MIN  = -FX_MAX - 1;
    localparam int     MAX_CYCLES = 2000000;
    localparam int     DRAIN_CYCLES = 260;

    // The scoreboard keeps its own copy of the coefficient store and the
    // viewport, predicts every project item, and compares the results in order.
    class window_scoreboard;
        logic [vpw_pkg::FIELD_W-1:0] coeffs [vpw_pkg::STORE_DEPTH];
        longint origin_x, origin_y, view_w, view_h;
        t_window_point expected_points [$];
        int mismatches;
        int points_checked;
        int failed_points;

        function new();
            foreach (coeffs[i]) coeffs[i] = '0;
            origin_x = 0;
            origin_y = 0;
            view_w = 0;
            view_h = 0;
            mismatches = 0;
            points_checked = 0;
            failed_points = 0;
        endfunction

        function void set_reg(vpw_pkg::t_cfg_idx idx, logic [vpw_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                vpw_pkg::CFG_ORIGIN_X: origin_x = longint'($signed(data));
                vpw_pkg::CFG_ORIGIN_Y: origin_y = longint'($signed(data));
                vpw_pkg::CFG_WIDTH:    view_w = longint'(data);
                vpw_pkg::CFG_HEIGHT:   view_h = longint'(data);
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v > FX_MAX) return FX_MAX;
            if (v < FX_MIN) return FX_MIN;
            return v;
        endfunction

        // One matrix row times a vector. The quarter-split sum keeps four
        // 63-bit products from overflowing 64 bits.
        function longint row_product(longint vec [4], int base, int r);
            longint hsum, lsum, p, h, c;
            hsum = 0;
            lsum = 0;
            for (int j = 0; j < 4; j++) begin
                c = longint'($signed(coeffs[(base + 4 * j + r) & 31]));
                p = vec[j] * c;
                h = p >>> 2;
                hsum += h;
                lsum += p - h * 4;
            end
            hsum = hsum + (lsum >>> 2) + (64'sd1 << (vpw_pkg::FRACTION_BITS - 3));
            return clamp(hsum >>> (vpw_pkg::FRACTION_BITS - 2));
        endfunction

        // Perspective divide, rounding halves away from zero.
        function longint persp_divide(longint clip, longint w);
            longint num, mag;
            longint unsigned n, d, q;
            num = clip * FX_ONE;
            n = (num < 0) ? longint'(-num) : num;
            d = (w < 0) ? longint'(-w) : w;
            q = (n + (d >> 1)) / d;
            mag = (q > 64'h7fff_ffff_ffff_ffff) ? 64'sh7fff_ffff_ffff_ffff : longint'(q);
            return clamp(((num < 0) != (w < 0)) ? -mag : mag);
        endfunction

        function longint viewport_map(longint origin, longint size, longint ndc);
            longint t;
            t = (FX_ONE + ndc) * size;
            return clamp(origin * FX_ONE + ((t + 1) >>> 1));
        endfunction

        function void note_item(t_vertex_item it);
            longint obj [4];
            longint eye [4];
            longint clip [4];
            t_window_point pt;
            if (it.mode == vpw_pkg::MODE_LOAD) begin
                coeffs[it.coeff_index] = it.coeff_value;
                return;
            end
            obj[0] = it.obj_x;
            obj[1] = it.obj_y;
            obj[2] = it.obj_z;
            obj[3] = FX_ONE;
            for (int r = 0; r < 4; r++) eye[r] = row_product(obj, 0, r);
            for (int r = 0; r < 4; r++) clip[r] = row_product(eye, 16, r);
            if (clip[3] == 0) begin
                pt = '{1'b0, '0, '0, '0};
            end else begin
                pt.ok = 1'b1;
                pt.win_x = viewport_map(origin_x, view_w, persp_divide(clip[0], clip[3]));
                pt.win_y = viewport_map(origin_y, view_h, persp_divide(clip[1], clip[3]));
                pt.win_z = clamp((FX_ONE + persp_divide(clip[2], clip[3]) + 1) >>> 1);
            end
            expected_points.push_back(pt);
        endfunction

        function void check_point(t_window_point got);
            t_window_point want;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result ok=%0b x=%0h y=%0h z=%0h",
                             got.ok, got.win_x, got.win_y, got.win_z);
                return;
            end
            want = expected_points.pop_front();
            points_checked++;
            if (!want.ok) failed_points++;
            if (got.ok !== want.ok || got.win_x !== want.win_x ||
                got.win_y !== want.win_y || got.win_z !== want.win_z) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: point %0d expected ok=%0b x=%0h y=%0h z=%0h,",
                              " got ok=%0b x=%0h y=%0h z=%0h"},
                             points_checked, want.ok, want.win_x, want.win_y, want.win_z,
                             got.ok, got.win_x, got.win_y, got.win_z);
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_in_valid;
    logic                               o_in_stall;
    logic                               i_mode;
    logic [vpw_pkg::ADDR_W-1:0]         i_coeff_index;
    logic signed [vpw_pkg::FIELD_W-1:0] i_coeff_value;
    logic signed [vpw_pkg::FIELD_W-1:0] i_obj_x;
    logic signed [vpw_pkg::FIELD_W-1:0] i_obj_y;
    logic signed [vpw_pkg::FIELD_W-1:0] i_obj_z;
    logic                               o_out_valid;
    logic                               i_out_stall;
    logic                               o_ok;
    logic signed [vpw_pkg::FIELD_W-1:0] o_win_x;
    logic signed [vpw_pkg::FIELD_W-1:0] o_win_y;
    logic signed [vpw_pkg::FIELD_W-1:0] o_win_z;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [vpw_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [vpw_pkg::CFG_DATA_W-1:0]     i_cfg_data;

    vertex_project_to_window DUT (.*);

    window_scoreboard sb = new();
    int  cycle_count = 0;
    int  items_sent = 0;
    int  stall_hold = 0;
    bit  steady = 0;         // When set, neither side inserts idle cycles.

    // 12 ns clock.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Results are taken at the rising edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_point('{o_ok, o_win_x, o_win_y, o_win_z});
    end

    // Receiver back-pressure: bursts of stall and of free flow, mostly short.
    always @(negedge i_clk) begin
        if (!i_rst_n || steady) begin
            i_out_stall = 1'b0;
            stall_hold = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            i_out_stall = ($urandom_range(0, 2) == 0);
            stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 4);
        end
    end

    // Idle length between input items: usually none or short, now and then long.
    function automatic int idle_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Coefficient content: mostly small values around the unit scale, sometimes
    // zero, one or any 32-bit pattern.
    function automatic logic [vpw_pkg::FIELD_W-1:0] pick_coeff();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        if (r == 1) return '0;
        if (r == 2) return 32'(FX_ONE);
        return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic logic [vpw_pkg::FIELD_W-1:0] pick_coord();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    endfunction

    // Drive one item and hold it until the block takes it.
    task automatic send_item(t_vertex_item it);
        int gap;
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_mode        = it.mode;
        i_coeff_index = it.coeff_index;
        i_coeff_value = it.coeff_value;
        i_obj_x       = it.obj_x;
        i_obj_y       = it.obj_y;
        i_obj_z       = it.obj_z;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        sb.note_item(it);
        items_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // The other fields of an item carry random bits so every input bit toggles.
    task automatic send_load(int idx, logic [vpw_pkg::FIELD_W-1:0] value);
        send_item('{vpw_pkg::MODE_LOAD, vpw_pkg::ADDR_W'(idx), value,
                    $urandom, $urandom, $urandom});
    endtask

    task automatic send_point(logic [vpw_pkg::FIELD_W-1:0] x, logic [vpw_pkg::FIELD_W-1:0] y,
                              logic [vpw_pkg::FIELD_W-1:0] z);
        send_item('{vpw_pkg::MODE_PROJECT, vpw_pkg::ADDR_W'($urandom), $urandom, x, y, z});
    endtask

    // Wait until every expected result has come and the block has gone quiet;
    // load items leave nothing to wait for, so a fixed drain follows.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(vpw_pkg::t_cfg_idx idx, logic [vpw_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_viewport(int ox, int oy, int w, int h);
        write_reg(vpw_pkg::CFG_ORIGIN_X, 16'(ox));
        write_reg(vpw_pkg::CFG_ORIGIN_Y, 16'(oy));
        write_reg(vpw_pkg::CFG_WIDTH, 16'(w));
        write_reg(vpw_pkg::CFG_HEIGHT, 16'(h));
    endtask

    // A well-formed burst: reload both matrices in random order, then project
    // points, with an occasional stray load mixed in as noise.
    task automatic matrix_burst(int points);
        int order [32];
        int j, t;
        foreach (order[i]) order[i] = i;
        for (int i = 31; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i]) send_load(order[i], pick_coeff());
        for (int i = 0; i < points; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_load($urandom_range(0, 31), pick_coeff());
            send_point(pick_coord(), pick_coord(), pick_coord());
        end
    endtask

    initial begin
        int sx, sy, sw, sh;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = vpw_pkg::MODE_LOAD;
        i_coeff_index = '0;
        i_coeff_value = '0;
        i_obj_x = '0;
        i_obj_y = '0;
        i_obj_z = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = vpw_pkg::CFG_ORIGIN_X;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. A point projected straight after reset sees an
        // all-zero store, so w is zero and the result reports failure.
        send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
        drain();
        set_viewport(0, 0, 640, 480);
        for (int i = 0; i < 4; i++) begin
            send_load(5 * i, 32'(FX_ONE));
            send_load(16 + 5 * i, 32'(FX_ONE));
        end
        send_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_8000);
        // Extreme coefficients at both ends of the store.
        send_load(0, 32'sh7fff_ffff);
        send_load(31, 32'sh8000_0000);
        send_point(32'sh0000_4000, 32'shffff_c000, 32'sh0001_0000);
        // A zero in the w corner of the projection makes w vanish again.
        send_load(31, 32'sh0000_0000);
        send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        send_load(31, 32'(FX_ONE));
        send_load(0, 32'(FX_ONE));

        // Hold the sender until every point so far has come back.
        drain();

        // Random part, one phase per viewport setting, extremes included.
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: set_viewport(-32768, -32768, 65535, 65535);
                1: set_viewport(32767, 32767, 65535, 65535);
                2: set_viewport(0, 0, 0, 0);
                3: set_viewport(-100, 200, 1, 65535);
                default: begin
                    sx = $urandom_range(0, 65535);
                    sy = $urandom_range(0, 65535);
                    sw = $urandom_range(0, 65535);
                    sh = $urandom_range(0, 4095);
                    set_viewport(sx, sy, sw, sh);
                end
            endcase
            steady = (phase == 2);
            matrix_burst(40);
            drain();
        end
        steady = 1'b0;

        $display("Sent %0d items, checked %0d projected points (%0d with zero w).",
                 items_sent, sb.points_checked, sb.failed_points);
        $display("Covered eight viewport settings, %0d mismatches.", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== vertex_project_to_window.f =====
hw/rtl/vpw_pkg.sv
hw/rtl/vpw_div.sv
hw/rtl/vertex_project_to_window.sv
tb/sv/tb_vertex_project_to_window.sv
